[sv/elfhc_pkg.sv]
package elfhc_pkg;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TOO_SMALL   = 4'd1;
    localparam logic [3:0] ST_MAGIC       = 4'd2;
    localparam logic [3:0] ST_CLASS       = 4'd3;
    localparam logic [3:0] ST_ENCODING    = 4'd4;
    localparam logic [3:0] ST_VERSION     = 4'd5;
    localparam logic [3:0] ST_MACHINE     = 4'd6;
    localparam logic [3:0] ST_TYPE        = 4'd7;
    localparam logic [3:0] ST_HDR_SIZE    = 4'd8;
    localparam logic [3:0] ST_ENTRY_SIZE  = 4'd9;
    localparam logic [3:0] ST_TABLE_BNDS  = 4'd10;
    localparam logic [3:0] ST_SEG_BNDS    = 4'd11;
    localparam logic [3:0] ST_OVERFLOW    = 4'd12;
    localparam logic [3:0] ST_ADDR_WINDOW = 4'd13;
    localparam logic [3:0] ST_NO_LOADABLE = 4'd14;
    localparam logic [3:0] ST_NOT_EXEC    = 4'd15;

    // item kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // header field values
    localparam logic [31:0] MAGIC_WORD   = 32'h464C_457F;
    localparam logic [7:0]  CLASS_64     = 8'd2;
    localparam logic [7:0]  DATA_LSB     = 8'd1;
    localparam logic [7:0]  IDENT_VER    = 8'd1;
    localparam logic [31:0] OBJ_VER      = 32'd1;
    localparam logic [15:0] MACHINE_X64  = 16'h003E;
    localparam logic [15:0] TYPE_EXEC    = 16'd2;
    localparam logic [15:0] HDR_BYTES    = 16'd64;
    localparam logic [15:0] PH_BYTES     = 16'd56;
    localparam logic [31:0] SEG_LOAD     = 32'd1;

    // user address window
    localparam logic [63:0] USER_LOW_LIMIT  = 64'h0000_0000_0000_1000;
    localparam logic [63:0] USER_HIGH_LIMIT = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [3:0] status;
        logic       exec_hit;
    } t_seg_result;

endpackage

[sv/elfhc_hdr_check.sv]
module elfhc_hdr_check (
    input  logic [55:0] i_ident_bytes,
    input  logic [31:0] i_version,
    input  logic [63:0] i_ids,
    input  logic [15:0] i_count,
    input  logic [63:0] i_image_size,
    input  logic [63:0] i_offset,
    output logic [3:0]  o_status
);

    logic [21:0] table_bytes;
    logic [64:0] table_end;

    // count * 56 as shifted adds
    assign table_bytes = {1'b0, i_count, 5'b0} + {2'b0, i_count, 4'b0} + {3'b0, i_count, 3'b0};
    assign table_end   = {1'b0, i_offset} + {43'b0, table_bytes};

    always_comb begin
        priority if (i_image_size < {48'b0, elfhc_pkg::HDR_BYTES}) begin
            o_status = elfhc_pkg::ST_TOO_SMALL;
        end else if (i_ident_bytes[31:0] != elfhc_pkg::MAGIC_WORD) begin
            o_status = elfhc_pkg::ST_MAGIC;
        end else if (i_ident_bytes[39:32] != elfhc_pkg::CLASS_64) begin
            o_status = elfhc_pkg::ST_CLASS;
        end else if (i_ident_bytes[47:40] != elfhc_pkg::DATA_LSB) begin
            o_status = elfhc_pkg::ST_ENCODING;
        end else if (i_ident_bytes[55:48] != elfhc_pkg::IDENT_VER
                     || i_version != elfhc_pkg::OBJ_VER) begin
            o_status = elfhc_pkg::ST_VERSION;
        end else if (i_ids[63:48] != elfhc_pkg::MACHINE_X64) begin
            o_status = elfhc_pkg::ST_MACHINE;
        end else if (i_ids[47:32] != elfhc_pkg::TYPE_EXEC) begin
            o_status = elfhc_pkg::ST_TYPE;
        end else if (i_ids[31:16] != elfhc_pkg::HDR_BYTES) begin
            o_status = elfhc_pkg::ST_HDR_SIZE;
        end else if (i_ids[15:0] != elfhc_pkg::PH_BYTES) begin
            o_status = elfhc_pkg::ST_ENTRY_SIZE;
        end else if (i_count == 16'd0) begin
            o_status = elfhc_pkg::ST_NO_LOADABLE;
        end else if (table_end[64] || table_end[63:0] > i_image_size) begin
            o_status = elfhc_pkg::ST_TABLE_BNDS;
        end else begin
            o_status = elfhc_pkg::ST_OK;
        end
    end

endmodule

[sv/elfhc_seg_check.sv]
module elfhc_seg_check (
    input  logic [63:0]            i_offset,
    input  logic [63:0]            i_address,
    input  logic                   i_exec_flag,
    input  logic [63:0]            i_file_length,
    input  logic [63:0]            i_mem_length,
    input  logic [63:0]            i_image_length,
    input  logic [63:0]            i_entry_point,
    output elfhc_pkg::t_seg_result o_result
);

    logic [64:0] file_range_end;
    logic [64:0] mem_end;

    assign file_range_end = {1'b0, i_offset} + {1'b0, i_file_length};
    assign mem_end        = {1'b0, i_address} + {1'b0, i_mem_length};

    always_comb begin
        o_result.exec_hit = 1'b0;
        priority if (file_range_end[64] || file_range_end[63:0] > i_image_length) begin
            o_result.status = elfhc_pkg::ST_SEG_BNDS;
        end else if (i_mem_length < i_file_length || mem_end[64]) begin
            o_result.status = elfhc_pkg::ST_OVERFLOW;
        end else if (i_address < elfhc_pkg::USER_LOW_LIMIT
                     || mem_end[63:0] > elfhc_pkg::USER_HIGH_LIMIT) begin
            o_result.status = elfhc_pkg::ST_ADDR_WINDOW;
        end else begin
            o_result.status   = elfhc_pkg::ST_OK;
            // entry point inside an executable segment
            o_result.exec_hit = i_exec_flag && i_entry_point >= i_address
                                && i_entry_point < mem_end[63:0];
        end
    end

endmodule

[sv/elf64_image_header_checker_core.sv]
// ELF64 x86-64 image header checker. Feed one header word (kind 0) and then
// count program header words (kind 1); a failing header returns its status
// word at once, otherwise the last program header word returns the final
// status (first error seen, else no loadable segment, else entry point not
// executable, else ok). Program header words with no open check are dropped
// silently, and a new header abandons any open check without a result. The
// block takes one word per cycle, unless a word is held back as below, and
// registers each status in a result register that drives the result port:
// an input register and a result register bracket the 64-bit add and compare
// logic, and the running check state is updated as the word leaves the input
// register, so the next word sees it.
// A word that produces a status waits in the input register, holding off new
// words, for as long as an earlier status sits unaccepted in the result
// register; words that produce nothing never wait.
module elf64_image_header_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [55:0] i_ident_bytes,
    input  logic [31:0] i_version,
    input  logic [63:0] i_ids,
    input  logic [15:0] i_count,
    input  logic [63:0] i_image_size,
    input  logic [63:0] i_offset,
    input  logic [63:0] i_address,
    input  logic [31:0] i_seg_type,
    input  logic [31:0] i_seg_flags,
    input  logic [63:0] i_file_length,
    input  logic [63:0] i_mem_length,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status
);

    // input register
    logic        r_in_valid;
    logic        r_kind;
    logic [55:0] r_ident_bytes;
    logic [31:0] r_version;
    logic [63:0] r_ids;
    logic [15:0] r_count;
    logic [63:0] r_image_size;
    logic [63:0] r_offset;
    logic [63:0] r_address;
    logic [31:0] r_seg_type;
    logic        r_exec_flag;
    logic [63:0] r_file_length;
    logic [63:0] r_mem_length;

    // check state
    logic        r_check_open,  n_check_open;
    logic [15:0] r_entries_left, n_entries_left;
    logic        r_saw_loadable, n_saw_loadable;
    logic        r_entry_in_exec, n_entry_in_exec;
    logic        r_error_seen,  n_error_seen;
    logic [3:0]  r_first_error, n_first_error;
    logic [63:0] r_entry_point, n_entry_point;
    logic [63:0] r_image_length, n_image_length;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_status;

    logic                   in_accept;
    logic                   out_free;
    logic                   advance;
    logic                   emit;
    logic [3:0]             emit_status;
    logic [3:0]             hdr_status;
    elfhc_pkg::t_seg_result seg_result;

    elfhc_hdr_check u_hdr_check (
        .i_ident_bytes (r_ident_bytes),
        .i_version     (r_version),
        .i_ids         (r_ids),
        .i_count       (r_count),
        .i_image_size  (r_image_size),
        .i_offset      (r_offset),
        .o_status      (hdr_status)
    );

    elfhc_seg_check u_seg_check (
        .i_offset       (r_offset),
        .i_address      (r_address),
        .i_exec_flag    (r_exec_flag),
        .i_file_length  (r_file_length),
        .i_mem_length   (r_mem_length),
        .i_image_length (r_image_length),
        .i_entry_point  (r_entry_point),
        .o_result       (seg_result)
    );

    // next check state and the status this word produces, if any
    always_comb begin
        n_check_open    = r_check_open;
        n_entries_left  = r_entries_left;
        n_saw_loadable  = r_saw_loadable;
        n_entry_in_exec = r_entry_in_exec;
        n_error_seen    = r_error_seen;
        n_first_error   = r_first_error;
        n_entry_point   = r_entry_point;
        n_image_length  = r_image_length;
        emit            = 1'b0;
        emit_status     = hdr_status;

        if (r_kind == elfhc_pkg::KIND_HEADER) begin
            // a header always starts over
            n_saw_loadable  = 1'b0;
            n_entry_in_exec = 1'b0;
            n_error_seen    = 1'b0;
            n_first_error   = elfhc_pkg::ST_OK;
            n_entry_point   = r_address;
            n_image_length  = r_image_size;
            n_entries_left  = r_count;
            n_check_open    = (hdr_status == elfhc_pkg::ST_OK);
            emit            = (hdr_status != elfhc_pkg::ST_OK);
            emit_status     = hdr_status;
        end else if (r_check_open) begin
            if (r_seg_type == elfhc_pkg::SEG_LOAD && !r_error_seen) begin
                n_saw_loadable = 1'b1;
                if (seg_result.status != elfhc_pkg::ST_OK) begin
                    n_error_seen  = 1'b1;
                    n_first_error = seg_result.status;
                end else if (seg_result.exec_hit) begin
                    n_entry_in_exec = 1'b1;
                end
            end
            n_entries_left = r_entries_left - 16'd1;
            if (n_entries_left == 16'd0) begin
                // last program header closes the check
                n_check_open = 1'b0;
                emit         = 1'b1;
                priority if (n_error_seen) begin
                    emit_status = n_first_error;
                end else if (!n_saw_loadable) begin
                    emit_status = elfhc_pkg::ST_NO_LOADABLE;
                end else if (!n_entry_in_exec) begin
                    emit_status = elfhc_pkg::ST_NOT_EXEC;
                end else begin
                    emit_status = elfhc_pkg::ST_OK;
                end
            end
        end
    end

    // the staged word moves on unless its status has nowhere to go
    assign out_free  = !r_out_valid || i_ready;
    assign advance   = r_in_valid && (!emit || out_free);
    assign o_ready   = !r_in_valid || advance;
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind        <= i_kind;
            r_ident_bytes <= i_ident_bytes;
            r_version     <= i_version;
            r_ids         <= i_ids;
            r_count       <= i_count;
            r_image_size  <= i_image_size;
            r_offset      <= i_offset;
            r_address     <= i_address;
            r_seg_type    <= i_seg_type;
            r_exec_flag   <= i_seg_flags[0];
            r_file_length <= i_file_length;
            r_mem_length  <= i_mem_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_open    <= 1'b0;
            r_entries_left  <= 16'd0;
            r_saw_loadable  <= 1'b0;
            r_entry_in_exec <= 1'b0;
            r_error_seen    <= 1'b0;
            r_first_error   <= elfhc_pkg::ST_OK;
            r_entry_point   <= 64'd0;
            r_image_length  <= 64'd0;
        end else if (advance) begin
            r_check_open    <= n_check_open;
            r_entries_left  <= n_entries_left;
            r_saw_loadable  <= n_saw_loadable;
            r_entry_in_exec <= n_entry_in_exec;
            r_error_seen    <= n_error_seen;
            r_first_error   <= n_first_error;
            r_entry_point   <= n_entry_point;
            r_image_length  <= n_image_length;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_status <= emit_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;

    // an open check always has program headers still to come
    a_open_has_entries : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_check_open |-> r_entries_left != 16'd0)
        else $error("check open with no entries left");

    // only segment failures are ever kept as the first error
    a_first_error_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_seen |-> (r_first_error == elfhc_pkg::ST_SEG_BNDS
                          || r_first_error == elfhc_pkg::ST_OVERFLOW
                          || r_first_error == elfhc_pkg::ST_ADDR_WINDOW))
        else $error("kept error is not a segment error");

    // no kept error code without the error flag
    a_first_error_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_error_seen |-> r_first_error == elfhc_pkg::ST_OK)
        else $error("stale first error");

    // a staged status word never overwrites one that is still waiting
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_status))
        else $error("pending status overwritten");

endmodule
